// File: design/bresenham_line_pixel_writer_assert.svh
// Assertion macros used by the checker of the line pixel writer.
`ifndef BRESENHAM_LINE_PIXEL_WRITER_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_WRITER_ASSERT_SVH

// Checked only outside reset.
`define BLPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BLPW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/blpw_pkg.sv
`timescale 1ns / 1ps
package blpw_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned ADDR_W  = 16;

  localparam logic [ADDR_W-1:0] BASE_RESET  = 16'hC000;
  localparam logic [ADDR_W-1:0] ROW_BYTES   = 16'd80;
  localparam logic [ADDR_W-1:0] LINE_STRIDE = 16'h0800;
  localparam logic [7:0]        LO_PLANE    = 8'h80;
  localparam logic [7:0]        HI_PLANE    = 8'h08;

  typedef enum logic {
    OP_LINE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        plane_mask;
    logic [7:0]        plane_bits;
    logic              on_screen;
  } pixel_t;

endpackage

// File: design/blpw_pixel.sv
`timescale 1ns / 1ps
module blpw_pixel
  import blpw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic        [ADDR_W-1:0]  base,
  input  logic        [1:0]         pen,
  output pixel_t                    pixel
);

  localparam logic [COORD_W-2:0] X_END = (COORD_W-1)'(SCREEN_WIDTH);
  localparam logic [COORD_W-2:0] Y_END = (COORD_W-1)'(SCREEN_HEIGHT);

  logic              on;
  logic [1:0]        p;
  logic [7:0]        lo;
  logic [7:0]        hi;
  logic [ADDR_W-1:0] row_part;
  logic [ADDR_W-1:0] line_part;
  logic [ADDR_W-1:0] col_part;

  assign on = !x[COORD_W-1] && !y[COORD_W-1] &&
              (x[COORD_W-2:0] < X_END) && (y[COORD_W-2:0] < Y_END);
  assign p  = x[1:0];
  assign lo = LO_PLANE >> p;
  assign hi = HI_PLANE >> p;

  assign row_part  = ADDR_W'(y[COORD_W-2:3]) * ROW_BYTES;
  assign line_part = ADDR_W'(y[2:0]) * LINE_STRIDE;
  assign col_part  = ADDR_W'(x[COORD_W-2:2]);

  always_comb begin
    pixel = '0;
    if (on) begin
      pixel.on_screen    = 1'b1;
      pixel.byte_address = base + row_part + line_part + col_part;
      pixel.plane_mask   = lo | hi;
      pixel.plane_bits   = (pen[0] ? lo : 8'h00) | (pen[1] ? hi : 8'h00);
    end
  end

endmodule

// File: design/bresenham_line_pixel_writer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  operation, start_x, start_y, end_x, end_y, pen
// output    out        out_valid/out_stall byte_address, plane_mask, plane_bits,
//                                         on_screen, last_pixel
// config    in         cfg_write          cfg_data (frame base address)
//
// One item per cycle while in_stall is low: a tick transfer steps the line state
// and loads the result register at the same edge; the result appears the cycle after.
// The critical path is the address sum base + row*80 + line*0x800 + column.
// rst (synchronous) clears the line to idle, drops any held result and sets the
// frame base to 0xC000. in_stall is high only while a held result is stalled.
module bresenham_line_pixel_writer
  import blpw_pkg::*;
#(
  parameter int COORD_LIMIT   = 999,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ADDR_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic [1:0]                pen,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ADDR_W-1:0]         byte_address,
  output logic [7:0]                plane_mask,
  output logic [7:0]                plane_bits,
  output logic                      on_screen,
  output logic                      last_pixel
);

  localparam logic signed [COORD_W-1:0] LIM_HI = COORD_W'(COORD_LIMIT);
  localparam logic signed [COORD_W-1:0] LIM_LO = -LIM_HI;

  logic [ADDR_W-1:0]         frame_base;
  logic signed [COORD_W-1:0] cur_x, cur_y, target_x, target_y;
  logic [COORD_W-1:0]        delta_x, delta_y;
  logic                      step_x_negative, step_y_negative;
  logic signed [ERR_W-1:0]   error_term;
  logic [1:0]                line_pen;
  logic                      busy;

  logic                      in_xfer, out_xfer, tick, start, in_range, last;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic signed [ERR_W:0]     e2;
  logic                      move_x, move_y;
  logic signed [ERR_W-1:0]   error_term_next;
  pixel_t                    pixel;

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  assign in_range = (start_x >= LIM_LO) && (start_x <= LIM_HI) &&
                    (start_y >= LIM_LO) && (start_y <= LIM_HI) &&
                    (end_x >= LIM_LO) && (end_x <= LIM_HI) &&
                    (end_y >= LIM_LO) && (end_y <= LIM_HI);
  assign start = in_xfer && (operation == OP_LINE) && in_range;
  assign tick  = in_xfer && (operation == OP_TICK) && busy;

  assign diff_x = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
  assign diff_y = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};

  assign last   = (cur_x == target_x) && (cur_y == target_y);
  assign e2     = {error_term, 1'b0};
  assign move_x = e2 > -$signed({3'b000, delta_y});
  assign move_y = e2 < $signed({3'b000, delta_x});
  assign error_term_next = error_term
                         - (move_x ? $signed({2'b00, delta_y}) : $signed(13'sd0))
                         + (move_y ? $signed({2'b00, delta_x}) : $signed(13'sd0));

  blpw_pixel #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_pixel (
    .x    (cur_x),
    .y    (cur_y),
    .base (frame_base),
    .pen  (line_pen),
    .pixel(pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base      <= BASE_RESET;
      cur_x           <= '0;
      cur_y           <= '0;
      target_x        <= '0;
      target_y        <= '0;
      delta_x         <= '0;
      delta_y         <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      error_term      <= '0;
      line_pen        <= '0;
      busy            <= 1'b0;
    end else begin
      if (cfg_write) begin
        frame_base <= cfg_data;
      end
      if (start) begin
        cur_x           <= start_x;
        cur_y           <= start_y;
        target_x        <= end_x;
        target_y        <= end_y;
        delta_x         <= diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
        delta_y         <= diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
        step_x_negative <= diff_x[COORD_W] || (diff_x == '0);
        step_y_negative <= diff_y[COORD_W] || (diff_y == '0);
        error_term      <= ERR_W'(diff_x[COORD_W] ? -diff_x : diff_x)
                         - ERR_W'(diff_y[COORD_W] ? -diff_y : diff_y);
        line_pen        <= pen;
        busy            <= 1'b1;
      end else if (tick) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          error_term <= error_term_next;
          if (move_x) begin
            cur_x <= step_x_negative ? cur_x - 11'sd1 : cur_x + 11'sd1;
          end
          if (move_y) begin
            cur_y <= step_y_negative ? cur_y - 11'sd1 : cur_y + 11'sd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      byte_address <= pixel.byte_address;
      plane_mask   <= pixel.plane_mask;
      plane_bits   <= pixel.plane_bits;
      on_screen    <= pixel.on_screen;
      last_pixel   <= last;
    end
  end

endmodule

// File: design/blpw_checker.sv
`timescale 1ns / 1ps
`include "bresenham_line_pixel_writer_assert.svh"
module blpw_checker
  import blpw_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      operation,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ADDR_W-1:0]         byte_address,
  input logic [7:0]                plane_mask,
  input logic [7:0]                plane_bits,
  input logic                      on_screen,
  input logic                      last_pixel
);

  `BLPW_ASSERT_ALWAYS(a_reset_drops_result, rst |=> !out_valid, "result valid after reset")

  `BLPW_ASSERT(a_hold_when_stalled,
    out_valid && out_stall |=> out_valid && $stable(byte_address) && $stable(plane_mask) &&
      $stable(plane_bits) && $stable(on_screen) && $stable(last_pixel),
    "stalled result changed")

  `BLPW_ASSERT(a_result_from_tick,
    $rose(out_valid) |-> $past(in_valid && !in_stall && operation == OP_TICK),
    "result without a tick transfer")

  `BLPW_ASSERT(a_off_screen_zero,
    out_valid && !on_screen |-> byte_address == '0 && plane_mask == '0 && plane_bits == '0,
    "off-screen pixel carries a write")

  `BLPW_ASSERT(a_mask_shape,
    out_valid && on_screen |-> $countones(plane_mask) == 2 && (plane_bits & ~plane_mask) == '0,
    "bad plane mask or bits outside mask")

endmodule

bind bresenham_line_pixel_writer blpw_checker u_blpw_checker (.*);
